/* src/dtf_pkg.sv */
// Shared types, character codes and tables of the decimal text to fixed-point converter.
package dtf_pkg;

    localparam int INT_W      = 32;
    localparam int FRAC_ACC_W = 60;
    localparam int DIG_CNT_W  = 5;
    localparam int IDX_OUT_W  = 16;
    localparam int VALUE_W    = 64;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_FORM
    } t_bstate;

    typedef struct packed {
        logic                  ok;
        logic                  neg;
        logic                  sat;
        logic [INT_W-1:0]      whole;
        logic [FRAC_ACC_W-1:0] frac_part;
        logic [DIG_CNT_W-1:0]  frac_cnt;
        logic [IDX_OUT_W-1:0]  chars;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [DIG_CNT_W-1:0] n);
        logic [FRAC_ACC_W-1:0] p;
        case (n)
            5'd0:    p = 60'd1;
            5'd1:    p = 60'd10;
            5'd2:    p = 60'd100;
            5'd3:    p = 60'd1000;
            5'd4:    p = 60'd10000;
            5'd5:    p = 60'd100000;
            5'd6:    p = 60'd1000000;
            5'd7:    p = 60'd10000000;
            5'd8:    p = 60'd100000000;
            5'd9:    p = 60'd1000000000;
            5'd10:   p = 60'd10000000000;
            5'd11:   p = 60'd100000000000;
            5'd12:   p = 60'd1000000000000;
            5'd13:   p = 60'd10000000000000;
            5'd14:   p = 60'd100000000000000;
            5'd15:   p = 60'd1000000000000000;
            5'd16:   p = 60'd10000000000000000;
            5'd17:   p = 60'd100000000000000000;
            5'd18:   p = 60'd1000000000000000000;
            default: p = 60'd1;
        endcase
        return p;
    endfunction

endpackage

/* src/dtf_if.sv */
// Valid/ready stream interfaces for the character input and the result output.
interface dtf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       string_start;

    modport source (output valid, output text_byte, output string_start, input ready);
    modport sink (input valid, input text_byte, input string_start, output ready);
endinterface

interface dtf_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] number_value;
    logic [15:0]        chars_consumed;
    logic               converted;
    logic               int_overflow;

    modport source (
        output valid, output number_value, output chars_consumed,
        output converted, output int_overflow, input ready
    );
    modport sink (
        input valid, input number_value, input chars_consumed,
        input converted, input int_overflow, output ready
    );
endinterface

/* src/decimal_text_to_fixed.sv */
// Top level of the decimal text to signed fixed-point converter.
//
// i_in carries one character per transfer (text_byte) with string_start
// marking the first character of a new string. o_out carries one result per
// string: number_value in signed Q(64-FRAC_BITS).FRAC_BITS, chars_consumed,
// converted and int_overflow. Characters after the end of a number give no
// result until the next string_start.
// The parser takes one character per cycle and hands each finished string
// to a two-entry job queue; i_in.ready drops only while that queue is full.
// The back end divides the fraction one quotient bit per cycle: it loads a
// job from the queue, runs the division state, then the form state writes
// the output register that drives o_out. While the receiver takes every
// result, strings of at least FRAC_BITS + 2 characters flow at one
// character per cycle.
// While the receiver stalls, the result waits in the output register, the
// back end finishes its next job and the queue fills before input stops.
// A synchronous reset empties the queue, drops o_out.valid and returns the
// parser to skipping white space.
module decimal_text_to_fixed #(
    parameter int FRAC_BITS       = 32,
    parameter int MAX_FRAC_DIGITS = 18,
    parameter int COUNT_BITS      = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtf_in_if.sink    i_in,
    dtf_out_if.source o_out
);

    logic                   push, pop;
    dtf_pkg::t_job          push_job, head_job;
    dtf_pkg::t_queue_status q_stat;

    dtf_front #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    dtf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    dtf_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

/* src/dtf_front.sv */
// Character parser: classifies each byte, accumulates digits and queues a job at the end.
module dtf_front #(
    parameter int FRAC_BITS       = 32,
    parameter int MAX_FRAC_DIGITS = 18,
    parameter int COUNT_BITS      = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dtf_in_if.sink                i_in,
    input  dtf_pkg::t_queue_status i_q_stat,
    output logic                  o_push,
    output dtf_pkg::t_job         o_job
);

    localparam logic [dtf_pkg::INT_W-1:0] INT_LIMIT =
        (FRAC_BITS >= 32) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
    localparam int PROD_W = dtf_pkg::INT_W + 4;

    dtf_pkg::t_phase                     r_phase, n_phase, eff_phase;
    logic                                r_neg, n_neg;
    logic [dtf_pkg::INT_W-1:0]           r_int, n_int;
    logic [dtf_pkg::FRAC_ACC_W-1:0]      r_frac, n_frac;
    logic [dtf_pkg::DIG_CNT_W-1:0]       r_cnt, n_cnt;
    logic [COUNT_BITS-1:0]               r_idx, n_idx;
    logic                                r_sat, n_sat;

    logic                                b_neg, b_sat;
    logic [dtf_pkg::INT_W-1:0]           b_int;
    logic [dtf_pkg::FRAC_ACC_W-1:0]      b_frac;
    logic [dtf_pkg::DIG_CNT_W-1:0]       b_cnt;
    logic [COUNT_BITS-1:0]               b_idx, idx_inc;

    logic [7:0]                          c;
    logic                                take, is_digit, is_space, is_sign, is_point;
    logic [3:0]                          digit;
    logic [PROD_W-1:0]                   int_prod;
    logic                                int_over;
    logic [dtf_pkg::INT_W-1:0]           int_next;
    logic [dtf_pkg::FRAC_ACC_W-1:0]      frac_next;
    logic [31:0]                         idx_wide;
    logic [dtf_pkg::IDX_OUT_W-1:0]       idx_clamp;
    logic                                do_int, do_frac, do_bump, emit_ok, emit_fail;

    assign c        = i_in.text_byte;
    assign take     = i_in.valid && i_in.ready;
    assign is_digit = (c >= dtf_pkg::CH_ZERO) && (c <= dtf_pkg::CH_NINE);
    assign is_space = (c == dtf_pkg::CH_BLANK) || ((c >= dtf_pkg::CH_TAB) && (c <= dtf_pkg::CH_CR));
    assign is_sign  = (c == dtf_pkg::CH_PLUS) || (c == dtf_pkg::CH_MINUS);
    assign is_point = (c == dtf_pkg::CH_POINT);
    assign digit    = 4'(c - dtf_pkg::CH_ZERO);

    assign eff_phase = i_in.string_start ? dtf_pkg::PH_SPACE : r_phase;
    assign b_neg  = i_in.string_start ? 1'b0 : r_neg;
    assign b_sat  = i_in.string_start ? 1'b0 : r_sat;
    assign b_int  = i_in.string_start ? '0 : r_int;
    assign b_frac = i_in.string_start ? '0 : r_frac;
    assign b_cnt  = i_in.string_start ? '0 : r_cnt;
    assign b_idx  = i_in.string_start ? '0 : r_idx;

    assign int_prod  = (PROD_W'(b_int) << 3) + (PROD_W'(b_int) << 1) + PROD_W'(digit);
    assign int_over  = int_prod > PROD_W'(INT_LIMIT);
    assign int_next  = int_over ? INT_LIMIT : int_prod[dtf_pkg::INT_W-1:0];
    assign frac_next = (b_frac << 3) + (b_frac << 1) + dtf_pkg::FRAC_ACC_W'(digit);
    assign idx_inc   = (b_idx == '1) ? b_idx : b_idx + 1'b1;
    assign idx_wide  = 32'(b_idx);
    assign idx_clamp = (idx_wide > 32'h0000_FFFF) ? 16'hFFFF : idx_wide[15:0];

    assign i_in.ready = !i_q_stat.full;

    always_comb begin
        n_phase = r_phase;
        if (take) begin
            case (eff_phase)
                dtf_pkg::PH_SPACE: begin
                    if (is_space) begin
                        n_phase = dtf_pkg::PH_SPACE;
                    end else if (is_sign) begin
                        n_phase = dtf_pkg::PH_SIGNED;
                    end else if (is_digit) begin
                        n_phase = dtf_pkg::PH_INT;
                    end else begin
                        n_phase = dtf_pkg::PH_DONE;
                    end
                end
                dtf_pkg::PH_SIGNED: begin
                    n_phase = is_digit ? dtf_pkg::PH_INT : dtf_pkg::PH_DONE;
                end
                dtf_pkg::PH_INT: begin
                    if (is_digit) begin
                        n_phase = dtf_pkg::PH_INT;
                    end else if (is_point) begin
                        n_phase = dtf_pkg::PH_FRAC;
                    end else begin
                        n_phase = dtf_pkg::PH_DONE;
                    end
                end
                dtf_pkg::PH_FRAC: begin
                    n_phase = is_digit ? dtf_pkg::PH_FRAC : dtf_pkg::PH_DONE;
                end
                default: begin
                    n_phase = dtf_pkg::PH_DONE;
                end
            endcase
        end
    end

    always_comb begin
        do_int    = 1'b0;
        do_frac   = 1'b0;
        do_bump   = 1'b0;
        emit_ok   = 1'b0;
        emit_fail = 1'b0;
        n_neg     = b_neg;
        case (eff_phase)
            dtf_pkg::PH_SPACE: begin
                if (is_space) begin
                    do_bump = 1'b1;
                end else if (is_sign) begin
                    do_bump = 1'b1;
                    n_neg   = (c == dtf_pkg::CH_MINUS);
                end else if (is_digit) begin
                    do_int = 1'b1;
                end else begin
                    emit_fail = 1'b1;
                end
            end
            dtf_pkg::PH_SIGNED: begin
                do_int    = is_digit;
                emit_fail = !is_digit;
            end
            dtf_pkg::PH_INT: begin
                do_int  = is_digit;
                do_bump = is_point;
                emit_ok = !is_digit && !is_point;
            end
            dtf_pkg::PH_FRAC: begin
                do_frac = is_digit && (b_cnt < dtf_pkg::DIG_CNT_W'(MAX_FRAC_DIGITS));
                do_bump = is_digit;
                emit_ok = !is_digit;
            end
            default: begin
            end
        endcase

        n_int  = do_int ? int_next : b_int;
        n_sat  = (do_int && int_over) ? 1'b1 : b_sat;
        n_frac = do_frac ? frac_next : b_frac;
        n_cnt  = do_frac ? b_cnt + 1'b1 : b_cnt;
        n_idx  = (do_bump || do_int) ? idx_inc : b_idx;

        o_push          = take && (emit_ok || emit_fail);
        o_job.ok        = emit_ok;
        o_job.neg       = b_neg;
        o_job.sat       = b_sat;
        o_job.whole     = b_int;
        o_job.frac_part = b_frac;
        o_job.frac_cnt  = b_cnt;
        o_job.chars     = idx_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dtf_pkg::PH_SPACE;
            r_neg   <= 1'b0;
            r_int   <= '0;
            r_frac  <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_sat   <= 1'b0;
        end else if (take) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_sat   <= n_sat;
        end
    end

    a_int_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_int <= INT_LIMIT)
        else $error("Integer accumulator exceeds its saturation limit.");

    a_frac_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= dtf_pkg::DIG_CNT_W'(MAX_FRAC_DIGITS))
        else $error("Fraction digit count exceeds the digit limit.");

endmodule

/* src/dtf_queue.sv */
// Two-entry job queue between the parser and the conversion back end.
module dtf_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  dtf_pkg::t_job          i_job,
    input  logic                   i_pop,
    output dtf_pkg::t_job          o_job,
    output dtf_pkg::t_queue_status o_stat
);

    dtf_pkg::t_job                r_mem [dtf_pkg::Q_DEPTH];
    logic [dtf_pkg::Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [dtf_pkg::Q_CNT_W-1:0]  r_count, n_count;
    logic                         do_push, do_pop;

    assign o_stat.full  = (r_count == dtf_pkg::Q_CNT_W'(dtf_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job        = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("Job pushed into a full queue.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dtf_pkg::Q_CNT_W'(dtf_pkg::Q_DEPTH))
        else $error("Queue occupancy exceeds its depth.");

endmodule

/* src/dtf_back.sv */
// Conversion back end: bit-serial fraction division, sign and output register.
module dtf_back #(
    parameter int FRAC_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dtf_pkg::t_job          i_job,
    input  dtf_pkg::t_queue_status i_q_stat,
    output logic                   o_pop,
    dtf_out_if.source              o_out
);

    localparam int ITER_W = $clog2(FRAC_BITS);
    localparam int REM_W  = dtf_pkg::FRAC_ACC_W + 1;

    dtf_pkg::t_bstate                 r_state, n_state;
    logic                             r_ok, r_neg, r_sat;
    logic [dtf_pkg::INT_W-1:0]        r_int;
    logic [dtf_pkg::IDX_OUT_W-1:0]    r_chars;
    logic [dtf_pkg::FRAC_ACC_W-1:0]   r_rem, r_den;
    logic [FRAC_BITS-1:0]             r_q;
    logic [ITER_W-1:0]                r_iter;

    logic                             r_out_valid;
    logic [dtf_pkg::VALUE_W-1:0]      r_value;
    logic [dtf_pkg::IDX_OUT_W-1:0]    r_out_chars;
    logic                             r_conv, r_ovf;

    logic                             load, div_step, form_write, out_free, last_iter;
    logic [REM_W-1:0]                 rem_sh, rem_sub;
    logic                             q_bit;
    logic [dtf_pkg::VALUE_W-1:0]      mag, signed_val;

    assign out_free  = !r_out_valid || o_out.ready;
    assign last_iter = (r_iter == ITER_W'(FRAC_BITS - 1));
    assign rem_sh    = {r_rem, 1'b0};
    assign rem_sub   = rem_sh - REM_W'(r_den);
    assign q_bit     = (rem_sh >= REM_W'(r_den));
    assign mag       = (dtf_pkg::VALUE_W'(r_int) << FRAC_BITS) | dtf_pkg::VALUE_W'(r_q);
    assign signed_val = r_neg ? (~mag + 1'b1) : mag;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dtf_pkg::B_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = dtf_pkg::B_DIV;
                end
            end
            dtf_pkg::B_DIV: begin
                if (last_iter) begin
                    n_state = dtf_pkg::B_FORM;
                end
            end
            dtf_pkg::B_FORM: begin
                if (out_free) begin
                    n_state = dtf_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = dtf_pkg::B_IDLE;
            end
        endcase
    end

    always_comb begin
        load       = 1'b0;
        div_step   = 1'b0;
        form_write = 1'b0;
        case (r_state)
            dtf_pkg::B_IDLE: load       = !i_q_stat.empty;
            dtf_pkg::B_DIV:  div_step   = 1'b1;
            dtf_pkg::B_FORM: form_write = out_free;
            default: begin
            end
        endcase
        o_pop = load;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ok    <= i_job.ok;
            r_neg   <= i_job.neg;
            r_sat   <= i_job.sat;
            r_int   <= i_job.whole;
            r_chars <= i_job.chars;
            r_rem   <= i_job.frac_part;
            r_den   <= dtf_pkg::pow10(i_job.frac_cnt);
            r_q     <= '0;
            r_iter  <= '0;
        end else if (div_step) begin
            r_rem  <= q_bit ? rem_sub[dtf_pkg::FRAC_ACC_W-1:0] : rem_sh[dtf_pkg::FRAC_ACC_W-1:0];
            r_q    <= {r_q[FRAC_BITS-2:0], q_bit};
            r_iter <= r_iter + 1'b1;
        end
        if (form_write) begin
            r_value     <= r_ok ? signed_val : '0;
            r_out_chars <= r_ok ? r_chars : '0;
            r_conv      <= r_ok;
            r_ovf       <= r_ok && r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtf_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (form_write) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.number_value   = r_value;
    assign o_out.chars_consumed = r_out_chars;
    assign o_out.converted      = r_conv;
    assign o_out.int_overflow   = r_ovf;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtf_pkg::B_DIV) |-> (r_rem < r_den))
        else $error("Division remainder is not below the divisor.");

    a_form_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        form_write |=> r_out_valid)
        else $error("Formed result did not reach the output register.");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the decimal text to fixed-point converter.
`timescale 1ns / 100ps

module testbench;
    import dtf_pkg::*;

    localparam int FRAC_BITS       = 32;
    localparam int MAX_FRAC_DIGITS = 18;
    localparam int COUNT_BITS      = 16;
    localparam logic [63:0] INT_LIMIT = (63 - FRAC_BITS >= 32) ? 64'hFFFF_FFFF
                                        : (64'd1 << (63 - FRAC_BITS)) - 64'd1;
    localparam int RANDOM_ITEMS  = 600;
    localparam int DRAIN_CYCLES  = 4 * (FRAC_BITS + 3);
    localparam int TIMEOUT_NS    = 20 * 600000;

    typedef struct packed {
        logic signed [63:0] value;
        logic [15:0]        chars;
        logic               conv;
        logic               ovf;
    } t_number_result;

    typedef struct {
        logic [7:0] ch;
        logic       start;
        int         row;
        bit         calm;
    } t_char_item;

    typedef struct {
        string          text;
        bit             nul;
        bit             typed;
        t_number_result want;
    } t_row;

    localparam t_number_result NO_CONVERSION = '0;

    logic i_clk;
    logic i_rst_n;

    dtf_in_if  text_ch ();
    dtf_out_if result_ch ();

    decimal_text_to_fixed #(
        .FRAC_BITS      (FRAC_BITS),
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
        .COUNT_BITS     (COUNT_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (text_ch),
        .o_out  (result_ch)
    );

    t_phase          pr_phase = PH_SPACE;
    logic            pr_neg   = 1'b0;
    logic [31:0]     pr_int   = '0;
    logic [63:0]     pr_frac  = '0;
    int              pr_fcnt  = 0;
    logic [COUNT_BITS-1:0] pr_idx = '0;
    logic            pr_sat   = 1'b0;

    t_number_result  expected_numbers[$];
    t_char_item      items[$];
    t_row            dir_rows[$];
    bit              pending_start = 1'b0;
    bit              calm_phase    = 1'b0;
    bit              stim_done     = 1'b0;
    int              drv_row       = -1;
    int              errors        = 0;

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_BLANK || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void bump_index();
        if (pr_idx != '1) pr_idx = pr_idx + 1'b1;
    endfunction

    function automatic void clear_parse();
        pr_phase = PH_SPACE;
        pr_neg   = 1'b0;
        pr_int   = '0;
        pr_frac  = '0;
        pr_fcnt  = 0;
        pr_idx   = '0;
        pr_sat   = 1'b0;
    endfunction

    function automatic void add_int_digit(input logic [7:0] c);
        logic [63:0] v;
        v = {32'd0, pr_int} * 64'd10 + 64'(c - CH_ZERO);
        if (v > INT_LIMIT) begin
            v      = INT_LIMIT;
            pr_sat = 1'b1;
        end
        pr_int = v[31:0];
        bump_index();
    endfunction

    function automatic bit parse_char(input logic [7:0] c, input logic first,
                                      output t_number_result r);
        logic [127:0] num;
        logic [127:0] den;
        logic [63:0]  mag;
        bit           done;
        bit           ok;
        int           k;
        done = 1'b0;
        ok   = 1'b0;
        r    = '0;
        if (first) clear_parse();
        case (pr_phase)
            PH_SPACE, PH_SIGNED: begin
                if (pr_phase == PH_SPACE && is_space(c)) begin
                    bump_index();
                end else if (pr_phase == PH_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
                    pr_neg   = (c == CH_MINUS);
                    pr_phase = PH_SIGNED;
                    bump_index();
                end else if (!is_digit(c)) begin
                    done = 1'b1;
                end else begin
                    pr_phase = PH_INT;
                    add_int_digit(c);
                end
            end
            PH_INT: begin
                if (is_digit(c)) begin
                    add_int_digit(c);
                end else if (c == CH_POINT) begin
                    pr_phase = PH_FRAC;
                    bump_index();
                end else begin
                    done = 1'b1;
                    ok   = 1'b1;
                end
            end
            PH_FRAC: begin
                if (is_digit(c)) begin
                    if (pr_fcnt < MAX_FRAC_DIGITS) begin
                        pr_frac = pr_frac * 64'd10 + 64'(c - CH_ZERO);
                        pr_fcnt++;
                    end
                    bump_index();
                end else begin
                    done = 1'b1;
                    ok   = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (done) begin
            if (ok) begin
                den = 128'd1;
                for (k = 0; k < pr_fcnt; k++) den = den * 128'd10;
                num = {64'd0, pr_frac} << FRAC_BITS;
                num = num / den;
                mag = ({32'd0, pr_int} << FRAC_BITS) | num[63:0];
                if (pr_neg) mag = -mag;
                r.value = mag;
                if (32'(pr_idx) > 32'h0000_FFFF) begin
                    r.chars = 16'hFFFF;
                end else begin
                    r.chars = 16'(pr_idx);
                end
                r.conv  = 1'b1;
                r.ovf   = pr_sat;
            end
            pr_phase = PH_DONE;
        end
        return done;
    endfunction

    function automatic void put(input logic [7:0] ch, input int row, input bit calm);
        t_char_item it;
        it.ch    = ch;
        it.start = pending_start;
        it.row   = row;
        it.calm  = calm;
        items.push_back(it);
        pending_start = 1'b0;
    endfunction

    function automatic void add_row(input string text, input bit nul, input bit typed,
                                    input t_number_result want);
        t_row r;
        r.text  = text;
        r.nul   = nul;
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [7:0] end_char();
        logic [7:0] ch;
        do ch = 8'($urandom_range(0, 255)); while (is_digit(ch) || ch == CH_POINT);
        return ch;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic int add_random_string(input bit calm);
        int n;
        int kind;
        int k;
        n             = 0;
        pending_start = 1'b1;
        kind          = $urandom_range(0, 99);
        if (kind < 80) begin
            if ($urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(1, 3)) begin
                    k = $urandom_range(0, 5);
                    put((k == 5) ? CH_BLANK : 8'(CH_TAB + k), -1, calm);
                    n++;
                end
            end
            k = $urandom_range(0, 2);
            if (k != 0) begin
                put((k == 1) ? CH_PLUS : CH_MINUS, -1, calm);
                n++;
            end
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 13)
                                                : $urandom_range(1, 9)) begin
                put(rand_digit(), -1, calm);
                n++;
            end
            if ($urandom_range(0, 2) != 0) begin
                put(CH_POINT, -1, calm);
                n++;
                repeat (($urandom_range(0, 4) == 0) ? $urandom_range(16, 22)
                                                    : $urandom_range(0, 8)) begin
                    put(rand_digit(), -1, calm);
                    n++;
                end
            end
            put(($urandom_range(0, 4) < 3) ? 8'h00 : end_char(), -1, calm);
            n++;
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)), -1, calm);
            end
        end else if (kind < 86) begin
            repeat ($urandom_range(1, 5)) begin
                put(8'($urandom_range(0, 255)), -1, calm);
                n++;
            end
        end else if (kind < 91) begin
            put(($urandom_range(0, 1) == 1) ? CH_PLUS : CH_MINUS, -1, calm);
            put(end_char(), -1, calm);
            n += 2;
        end else if (kind < 96) begin
            put(CH_POINT, -1, calm);
            put(rand_digit(), -1, calm);
            put(8'h00, -1, calm);
            n += 3;
        end else begin
            repeat ($urandom_range(1, 4)) begin
                put(rand_digit(), -1, calm);
                n++;
            end
        end
        return n;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : drive
        t_char_item it;
        int         counted;
        int         tx_left;
        bit         tx_quiet;
        int         r;
        int         k;
        text_ch.valid        <= 1'b0;
        text_ch.text_byte    <= 8'h00;
        text_ch.string_start <= 1'b0;
        counted  = 0;
        tx_left  = 0;
        tx_quiet = 1'b0;

        add_row("", 1, 1, NO_CONVERSION);
        add_row("0", 1, 1, '{64'sh0, 16'd1, 1'b1, 1'b0});
        add_row("-0", 1, 1, '{64'sh0, 16'd2, 1'b1, 1'b0});
        add_row("-1", 1, 1, '{64'shFFFF_FFFF_0000_0000, 16'd2, 1'b1, 1'b0});
        add_row("+", 1, 1, NO_CONVERSION);
        add_row("\011\012\013\014\015 -x", 0, 1, NO_CONVERSION);
        add_row(".5", 1, 1, NO_CONVERSION);
        add_row("2147483647", 1, 1, '{64'sh7FFF_FFFF_0000_0000, 16'd10, 1'b1, 1'b0});
        add_row("2147483648", 1, 1, '{64'sh7FFF_FFFF_0000_0000, 16'd10, 1'b1, 1'b1});
        add_row("-99999999999.9999999999", 1, 0, NO_CONVERSION);
        add_row("1.5", 1, 1, '{64'sh0000_0001_8000_0000, 16'd3, 1'b1, 1'b0});
        add_row("3.", 1, 1, '{64'sh0000_0003_0000_0000, 16'd2, 1'b1, 1'b0});
        add_row("0.1234567890123456789", 1, 0, NO_CONVERSION);
        add_row(" +42.0625", 1, 0, NO_CONVERSION);
        add_row("12ab", 0, 1, '{64'sh0000_000C_0000_0000, 16'd2, 1'b1, 1'b0});
        add_row("\377", 0, 1, NO_CONVERSION);
        add_row("77", 0, 0, NO_CONVERSION);
        add_row("9.999999999999999999", 1, 0, NO_CONVERSION);

        foreach (dir_rows[i]) begin
            pending_start = 1'b1;
            for (k = 0; k < dir_rows[i].text.len(); k++) put(dir_rows[i].text[k], i, 0);
            if (dir_rows[i].nul) put(8'h00, i, 0);
        end

        while (counted < RANDOM_ITEMS) counted += add_random_string(0);

        repeat (30) r = add_random_string(1);

        while (i_rst_n !== 1'b1) @(posedge i_clk);

        foreach (items[i]) begin
            it = items[i];
            if (it.calm) calm_phase = 1'b1;
            if (tx_left == 0) begin
                tx_quiet = ($urandom_range(0, 2) == 0);
                tx_left  = $urandom_range(20, 80);
            end
            tx_left--;
            if (!calm_phase && !tx_quiet && $urandom_range(0, 4) == 0) begin
                text_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            text_ch.valid        <= 1'b1;
            text_ch.text_byte    <= it.ch;
            text_ch.string_start <= it.start;
            drv_row              <= it.row;
            @(posedge i_clk);
            while (!text_ch.ready) @(posedge i_clk);
        end
        text_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin : receive
        int rx_stall;
        int rx_left;
        bit rx_quiet;
        result_ch.ready <= 1'b0;
        rx_stall = 0;
        rx_left  = 0;
        rx_quiet = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_left == 0) begin
                rx_quiet = ($urandom_range(0, 2) == 0);
                rx_left  = $urandom_range(20, 80);
            end
            rx_left--;
            if (rx_stall > 0) begin
                result_ch.ready <= 1'b0;
                rx_stall--;
            end else begin
                result_ch.ready <= 1'b1;
                if (!calm_phase && !rx_quiet && $urandom_range(0, 5) == 0) begin
                    rx_stall = $urandom_range(1, 14);
                end
            end
        end
    end

    always @(posedge i_clk) begin : check
        t_number_result want;
        t_number_result got;
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_numbers.size() == 0) begin
                    $error("unexpected result transfer: number_value %h", result_ch.number_value);
                    errors++;
                end else begin
                    want = expected_numbers.pop_front();
                    if (result_ch.number_value !== want.value) begin
                        $error("number_value: expected %h, actual %h",
                               want.value, result_ch.number_value);
                        errors++;
                    end
                    if (result_ch.chars_consumed !== want.chars) begin
                        $error("chars_consumed: expected %0d, actual %0d",
                               want.chars, result_ch.chars_consumed);
                        errors++;
                    end
                    if (result_ch.converted !== want.conv) begin
                        $error("converted: expected %b, actual %b",
                               want.conv, result_ch.converted);
                        errors++;
                    end
                    if (result_ch.int_overflow !== want.ovf) begin
                        $error("int_overflow: expected %b, actual %b",
                               want.ovf, result_ch.int_overflow);
                        errors++;
                    end
                end
            end
            if (text_ch.valid && text_ch.ready) begin
                if (parse_char(text_ch.text_byte, text_ch.string_start, got)) begin
                    if (drv_row >= 0 && dir_rows[drv_row].typed) got = dir_rows[drv_row].want;
                    expected_numbers.push_back(got);
                end
            end
        end
    end

    initial begin : finish_run
        wait (stim_done);
        while (expected_numbers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_numbers.size() != 0) begin
            $error("result transfers: expected %0d more, actual 0", expected_numbers.size());
            errors++;
        end
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
